[rtl/vsc_pkg.sv]
// shared constants and result codes for the version string compare block
package vsc_pkg;

  // character codes
  localparam logic [7:0] CHAR_DOT  = 8'h2e;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // decimal base, part width and accumulator width
  localparam logic [3:0]  RADIX      = 4'd10;
  localparam int          PART_W     = 16;
  localparam int          ACC_W      = 20;

  // default number of dot separated parts
  localparam int PART_COUNT_DEF = 3;

  // comparison codes
  localparam logic signed [1:0] ORDER_EQUAL = 2'sb00;
  localparam logic signed [1:0] ORDER_NEWER = 2'sb01;
  localparam logic signed [1:0] ORDER_OLDER = 2'sb11;

endpackage

[rtl/vsc_if.sv]
// valid/ready channel interfaces for the character and result streams
interface vsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_char;
  logic       left_present;
  logic [7:0] right_char;
  logic       right_present;
  logic       last;

  modport source (
    output valid, left_char, left_present, right_char, right_present, last,
    input  ready
  );
  modport sink (
    input  valid, left_char, left_present, right_char, right_present, last,
    output ready
  );
endinterface

interface vsc_out_if;
  logic              valid;
  logic              ready;
  logic              left_valid;
  logic              right_valid;
  logic              both_valid;
  logic signed [1:0] order;

  modport source (
    output valid, left_valid, right_valid, both_valid, order,
    input  ready
  );
  modport sink (
    input  valid, left_valid, right_valid, both_valid, order,
    output ready
  );
endinterface

[rtl/version_string_compare_top.sv]
// version string checker and comparator, one character pair per cycle while the result slot is free
// Path: the last character pair of a string pair passes the input register, then the
//   result register, which presents the result of that string pair.
// Throughput: one character pair per cycle unless a final pair waits on a full result;
//   the per-lane multiply-by-ten accumulate and the part compare sit between both registers.
// Reset: synchronous active low rst_n clears both lanes and empties both registers.
module version_string_compare_top #(
  parameter int PART_COUNT = vsc_pkg::PART_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vsc_in_if.sink      in_ch,
  vsc_out_if.source   out_ch
);

  localparam int IDX_W = (PART_COUNT > 1) ? $clog2(PART_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PART_COUNT - 1);

  typedef struct packed {
    logic [IDX_W-1:0]                          idx;
    logic                                      seen;
    logic                                      failed;
    logic [PART_COUNT-1:0][vsc_pkg::PART_W-1:0] parts;
  } lane_t;

  // one character step of a lane
  function automatic lane_t lane_take(lane_t s, logic [7:0] c);
    lane_t                     n;
    logic [3:0]                dig;
    logic [vsc_pkg::ACC_W-1:0] cur;
    logic [vsc_pkg::ACC_W-1:0] acc;
    n   = s;
    dig = 4'(c - vsc_pkg::CHAR_ZERO);
    cur = vsc_pkg::ACC_W'(s.parts[s.idx]);
    acc = (cur << 3) + (cur << 1) + vsc_pkg::ACC_W'(dig);
    if (!s.failed) begin
      if (c >= vsc_pkg::CHAR_ZERO && c <= vsc_pkg::CHAR_NINE) begin
        if (acc[vsc_pkg::ACC_W-1:vsc_pkg::PART_W] != '0) begin
          n.failed = 1'b1;
        end else begin
          n.parts[s.idx] = acc[vsc_pkg::PART_W-1:0];
          n.seen         = 1'b1;
        end
      end else if (c == vsc_pkg::CHAR_DOT) begin
        if (!s.seen || s.idx == IDX_LAST) begin
          n.failed = 1'b1;
        end else begin
          n.idx  = s.idx + 1'b1;
          n.seen = 1'b0;
        end
      end else begin
        n.failed = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic lane_ok(lane_t s);
    return !s.failed && s.seen && (s.idx == IDX_LAST);
  endfunction

  // first differing part decides
  function automatic logic signed [1:0] part_order(lane_t a, lane_t b);
    logic              found;
    logic signed [1:0] ord;
    found = 1'b0;
    ord   = vsc_pkg::ORDER_EQUAL;
    for (int i = 0; i < PART_COUNT; i++) begin
      if (!found && a.parts[i] != b.parts[i]) begin
        found = 1'b1;
        ord   = (a.parts[i] < b.parts[i]) ? vsc_pkg::ORDER_OLDER : vsc_pkg::ORDER_NEWER;
      end
    end
    return ord;
  endfunction

  // input register
  logic       s1_v_r;
  logic [7:0] s1_lchar_r;
  logic       s1_lpres_r;
  logic [7:0] s1_rchar_r;
  logic       s1_rpres_r;
  logic       s1_last_r;

  // lane state
  lane_t lane_l_r, lane_l_nxt, lane_l_upd;
  lane_t lane_r_r, lane_r_nxt, lane_r_upd;

  // result register
  logic              out_v_r;
  logic              out_lv_r, out_lv_nxt;
  logic              out_rv_r, out_rv_nxt;
  logic signed [1:0] out_ord_r, out_ord_nxt;

  logic s1_go;
  logic in_xfer;
  logic res_load;

  // a non-final item never needs the result slot
  assign s1_go    = s1_v_r && (!s1_last_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign res_load = s1_go && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_lchar_r <= in_ch.left_char;
      s1_lpres_r <= in_ch.left_present;
      s1_rchar_r <= in_ch.right_char;
      s1_rpres_r <= in_ch.right_present;
      s1_last_r  <= in_ch.last;
    end
  end

  // lane update, then compare on the final item
  always_comb begin
    lane_l_upd = s1_lpres_r ? lane_take(lane_l_r, s1_lchar_r) : lane_l_r;
    lane_r_upd = s1_rpres_r ? lane_take(lane_r_r, s1_rchar_r) : lane_r_r;
    out_lv_nxt = lane_ok(lane_l_upd);
    out_rv_nxt = lane_ok(lane_r_upd);
    out_ord_nxt = (out_lv_nxt && out_rv_nxt) ? part_order(lane_l_upd, lane_r_upd)
                                             : vsc_pkg::ORDER_EQUAL;
    lane_l_nxt = lane_l_r;
    lane_r_nxt = lane_r_r;
    if (s1_go) begin
      lane_l_nxt = s1_last_r ? '0 : lane_l_upd;
      lane_r_nxt = s1_last_r ? '0 : lane_r_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_l_r <= '0;
      lane_r_r <= '0;
    end else begin
      lane_l_r <= lane_l_nxt;
      lane_r_r <= lane_r_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_lv_r  <= out_lv_nxt;
      out_rv_r  <= out_rv_nxt;
      out_ord_r <= out_ord_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.left_valid  = out_lv_r;
  assign out_ch.right_valid = out_rv_r;
  assign out_ch.both_valid  = out_lv_r && out_rv_r;
  assign out_ch.order       = out_ord_r;

  // a nonzero order only comes from two well formed strings
  a_order_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ord_r != vsc_pkg::ORDER_EQUAL) |-> (out_lv_r && out_rv_r))
    else $error("order set while a lane is invalid");

  // order never takes the unused code
  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_ord_r != 2'sb10))
    else $error("order holds an undefined code");

  // a final item waiting on a full result slot blocks the input
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_last_r && out_v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while final item is stalled");

  // lanes are clean after a final item
  a_lanes_clear: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (lane_l_r == '0 && lane_r_r == '0))
    else $error("lane state not cleared after final item");

  // a final item always fills the result slot
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_v_r)
    else $error("result lost after final item");

endmodule

[test/testbench.sv]
// self-checking testbench for the version string compare block
module testbench;

  localparam int PARTS       = vsc_pkg::PART_COUNT_DEF;
  localparam int ITEM_GOAL   = 1700;
  localparam int PHASE_A_END = 600;
  localparam int PHASE_B_END = 1200;
  localparam int STALL_LIMIT = 3000;
  localparam logic [vsc_pkg::PART_W-1:0] PART_MAX = {vsc_pkg::PART_W{1'b1}};

  typedef logic [7:0] text_t[$];

  // running scan of one lane
  typedef struct packed {
    logic [1:0]                            part_idx;
    logic                                  digit_seen;
    logic                                  failed;
    logic [PARTS-1:0][vsc_pkg::PART_W-1:0] parts;
  } scan_t;

  typedef struct packed {
    logic              left_valid;
    logic              right_valid;
    logic              both_valid;
    logic signed [1:0] order;
  } verdict_t;

  typedef struct packed {
    logic [7:0] left_char;
    logic       left_present;
    logic [7:0] right_char;
    logic       right_present;
    logic       last;
  } char_pair_t;

  // verdict typed into the table, or taken from the predictor
  typedef struct packed {
    logic     typed;
    verdict_t want;
  } pinned_t;

  typedef struct {
    string    left_text;
    string    right_text;
    logic     typed;
    verdict_t want;
  } row_t;

  localparam verdict_t V_EQUAL = '{1'b1, 1'b1, 1'b1, vsc_pkg::ORDER_EQUAL};
  localparam verdict_t V_NEWER = '{1'b1, 1'b1, 1'b1, vsc_pkg::ORDER_NEWER};
  localparam verdict_t V_OLDER = '{1'b1, 1'b1, 1'b1, vsc_pkg::ORDER_OLDER};
  localparam verdict_t V_LBAD  = '{1'b0, 1'b1, 1'b0, vsc_pkg::ORDER_EQUAL};
  localparam verdict_t V_RBAD  = '{1'b1, 1'b0, 1'b0, vsc_pkg::ORDER_EQUAL};
  localparam verdict_t V_NONE  = '{1'b0, 1'b0, 1'b0, vsc_pkg::ORDER_EQUAL};

  logic clk;
  logic rst_n;

  vsc_in_if  in_ch ();
  vsc_out_if out_ch ();

  version_string_compare_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scan_t     left_track;
  scan_t     right_track;
  verdict_t  verdicts_due[$];
  pinned_t   pinned_verdicts[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        verdicts_seen = 0;
  int        newer_seen = 0;
  int        older_seen = 0;
  int        invalid_seen = 0;
  int        quiet_cycles = 0;
  int        feed_idle = 15;
  int        drain_idle = 65;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor: fold one character into a lane scan
  function automatic scan_t lane_absorb(scan_t s, logic [7:0] c);
    scan_t                     n;
    logic [1:0]                idx;
    logic [vsc_pkg::ACC_W-1:0] acc;
    n = s;
    idx = s.part_idx;
    if (s.failed) return s;
    if (int'(idx) >= PARTS) begin
      n.failed = 1'b1;
      return n;
    end
    if (c >= vsc_pkg::CHAR_ZERO && c <= vsc_pkg::CHAR_NINE) begin
      acc = vsc_pkg::ACC_W'(s.parts[idx]) * vsc_pkg::ACC_W'(vsc_pkg::RADIX) +
            vsc_pkg::ACC_W'(c - vsc_pkg::CHAR_ZERO);
      if (acc > vsc_pkg::ACC_W'(PART_MAX)) begin
        n.failed = 1'b1;
      end else begin
        n.parts[idx] = acc[vsc_pkg::PART_W-1:0];
        n.digit_seen = 1'b1;
      end
    end else if (c == vsc_pkg::CHAR_DOT) begin
      if (!s.digit_seen || int'(idx) + 1 >= PARTS) begin
        n.failed = 1'b1;
      end else begin
        n.part_idx = idx + 2'd1;
        n.digit_seen = 1'b0;
      end
    end else begin
      n.failed = 1'b1;
    end
    return n;
  endfunction

  // predictor: validity of both lanes and the part-by-part ordering
  function automatic verdict_t judge_pair(scan_t a, scan_t b);
    verdict_t v;
    logic     decided;
    int       i;
    v.left_valid  = !a.failed && a.digit_seen && int'(a.part_idx) == PARTS - 1;
    v.right_valid = !b.failed && b.digit_seen && int'(b.part_idx) == PARTS - 1;
    v.both_valid  = v.left_valid && v.right_valid;
    v.order = vsc_pkg::ORDER_EQUAL;
    decided = 1'b0;
    if (v.both_valid) begin
      for (i = 0; i < PARTS; i++) begin
        if (!decided && a.parts[i] != b.parts[i]) begin
          v.order = (a.parts[i] < b.parts[i]) ? vsc_pkg::ORDER_OLDER
                                               : vsc_pkg::ORDER_NEWER;
          decided = 1'b1;
        end
      end
    end
    return v;
  endfunction

  task automatic flag_mismatch(string what);
    $display("testbench: mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // monitor: check result transfers, predict on input transfers, watchdog
  always @(posedge clk) begin : monitor
    verdict_t due;
    pinned_t  pin;
    verdict_t calc;
    if (rst_n) begin
      // result side
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch("result transfer with nothing due");
        end else begin
          due = verdicts_due.pop_front();
          verdicts_seen++;
          if (!due.both_valid) invalid_seen++;
          else if (due.order == vsc_pkg::ORDER_NEWER) newer_seen++;
          else if (due.order == vsc_pkg::ORDER_OLDER) older_seen++;
          if (out_ch.left_valid !== due.left_valid)
            flag_mismatch($sformatf("left_valid got %b want %b",
                                    out_ch.left_valid, due.left_valid));
          if (out_ch.right_valid !== due.right_valid)
            flag_mismatch($sformatf("right_valid got %b want %b",
                                    out_ch.right_valid, due.right_valid));
          if (out_ch.both_valid !== due.both_valid)
            flag_mismatch($sformatf("both_valid got %b want %b",
                                    out_ch.both_valid, due.both_valid));
          if (out_ch.order !== due.order)
            flag_mismatch($sformatf("order got %b want %b", out_ch.order, due.order));
        end
      end
      // character side
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.left_present) left_track = lane_absorb(left_track, in_ch.left_char);
        if (in_ch.right_present) right_track = lane_absorb(right_track, in_ch.right_char);
        if (in_ch.last) begin
          calc = judge_pair(left_track, right_track);
          pin = '0;
          if (pinned_verdicts.size() != 0) pin = pinned_verdicts.pop_front();
          verdicts_due.push_back(pin.typed ? pin.want : calc);
          left_track = '0;
          right_track = '0;
        end
      end
      // watchdog on cycles with no transfer
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
          $display("testbench: errors");
          $finish;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= drain_idle);
    end
  end

  function automatic text_t to_text(string s);
    text_t t;
    int    k;
    for (k = 0; k < s.len(); k++) t.push_back(s[k]);
    return t;
  endfunction

  // one character pair transfer, with sender gaps ahead of it
  task automatic drive_item(char_pair_t it);
    if (items_sent < PHASE_A_END) begin
      feed_idle = 15;
      drain_idle = 65;
    end else if (items_sent < PHASE_B_END) begin
      feed_idle = 65;
      drain_idle = 15;
    end else begin
      feed_idle = 0;
      drain_idle = 0;
    end
    while ($urandom_range(99) < feed_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.left_char     = it.left_char;
    in_ch.left_present  = it.left_present;
    in_ch.right_char    = it.right_char;
    in_ch.right_present = it.right_present;
    in_ch.last          = it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // stream two strings side by side; gappy lanes skip some items
  task automatic send_strings(text_t l, text_t r, logic gappy, logic typed,
                              verdict_t want);
    char_pair_t it;
    int         li;
    int         ri;
    li = 0;
    ri = 0;
    pinned_verdicts.push_back(pinned_t'{typed, want});
    do begin
      it.left_present  = (li < l.size()) && (!gappy || $urandom_range(99) < 80);
      it.right_present = (ri < r.size()) && (!gappy || $urandom_range(99) < 80);
      it.left_char  = it.left_present ? l[li] : 8'($urandom_range(255));
      it.right_char = it.right_present ? r[ri] : 8'($urandom_range(255));
      li += int'(it.left_present);
      ri += int'(it.right_present);
      it.last = (li >= l.size()) && (ri >= r.size()) &&
                !(gappy && $urandom_range(7) == 0);
      drive_item(it);
    end while (!it.last);
  endtask

  function automatic int pick_part();
    case ($urandom_range(3))
      0: return $urandom_range(9);
      1: return $urandom_range(999);
      2: return $urandom_range(65535);
      default: return $urandom_range(65535, 65530);
    endcase
  endfunction

  function automatic text_t version_text(int p[PARTS]);
    text_t t;
    string s;
    int    i;
    for (i = 0; i < PARTS; i++) begin
      if (i != 0) t.push_back(vsc_pkg::CHAR_DOT);
      s = $sformatf("%0d", p[i]);
      // leading zeros now and then
      if ($urandom_range(9) == 0) s = {"00", s};
      t = {t, to_text(s)};
    end
    return t;
  endfunction

  // mostly well formed, some oversize parts, mutated forms and noise
  function automatic text_t shape_lane(int p[PARTS]);
    text_t t;
    int    k;
    int    n;
    int    pos;
    k = $urandom_range(99);
    if (k >= 95) begin
      n = $urandom_range(8);
      repeat (n) begin
        case ($urandom_range(3))
          0, 1: t.push_back(vsc_pkg::CHAR_ZERO + 8'($urandom_range(9)));
          2: t.push_back(vsc_pkg::CHAR_DOT);
          default: t.push_back(8'($urandom_range(255)));
        endcase
      end
      return t;
    end
    if (k >= 70 && k < 80) p[$urandom_range(PARTS - 1)] = $urandom_range(99999, 65536);
    t = version_text(p);
    if (k >= 80) begin
      pos = $urandom_range(t.size() - 1);
      case ($urandom_range(4))
        0: t.insert(pos, 8'($urandom_range(255)));
        1: t[pos] = 8'($urandom_range(255));
        2: t.delete(pos);
        3: begin
          t.push_back(vsc_pkg::CHAR_DOT);
          if ($urandom_range(1) == 1)
            t.push_back(vsc_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        end
        default: while (t.size() > pos) void'(t.pop_back());
      endcase
    end
    return t;
  endfunction

  task automatic send_random_pair();
    int lp[PARTS];
    int rp[PARTS];
    int i;
    for (i = 0; i < PARTS; i++) lp[i] = pick_part();
    // right side equal, one part apart, or unrelated
    case ($urandom_range(2))
      0: rp = lp;
      1: begin
        rp = lp;
        rp[$urandom_range(PARTS - 1)] = pick_part();
      end
      default: for (i = 0; i < PARTS; i++) rp[i] = pick_part();
    endcase
    send_strings(shape_lane(lp), shape_lane(rp), $urandom_range(3) != 0, 1'b0, V_NONE);
  endtask

  // stimulus and end of run
  initial begin
    row_t rows[$];
    int   r;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.left_char     = '0;
    in_ch.left_present  = 1'b0;
    in_ch.right_char    = '0;
    in_ch.right_present = 1'b0;
    in_ch.last          = 1'b0;
    left_track          = '0;
    right_track         = '0;

    // directed table
    rows.push_back(row_t'{"", "", 1'b1, V_NONE});
    rows.push_back(row_t'{"1.2.3", "1.2.3", 1'b1, V_EQUAL});
    rows.push_back(row_t'{"65535.65535.65535", "0.0.0", 1'b1, V_NEWER});
    rows.push_back(row_t'{"0.0.0", "65535.65535.65535", 1'b1, V_OLDER});
    rows.push_back(row_t'{"65536.1.1", "1.1.1", 1'b1, V_LBAD});
    rows.push_back(row_t'{"1.1.1", "1.1.99999", 1'b1, V_RBAD});
    rows.push_back(row_t'{"1.2.3", "1.2.4", 1'b1, V_OLDER});
    rows.push_back(row_t'{"2.0.0", "1.9.9", 1'b1, V_NEWER});
    rows.push_back(row_t'{"1.3.0", "1.2.9", 1'b1, V_NEWER});
    rows.push_back(row_t'{"1..3", "1.2.3", 1'b1, V_LBAD});
    rows.push_back(row_t'{"1.2.", "1.2.3", 1'b1, V_LBAD});
    rows.push_back(row_t'{"1.2.3", "1.2.3.4", 1'b1, V_RBAD});
    rows.push_back(row_t'{"1.2", "1.2", 1'b1, V_NONE});
    rows.push_back(row_t'{"1.2.3", "1.a.3", 1'b1, V_RBAD});
    rows.push_back(row_t'{".1.2", "007.08.09", 1'b1, V_LBAD});
    rows.push_back(row_t'{"1.2.3x", "1.2.3\377", 1'b1, V_NONE});
    rows.push_back(row_t'{"v1.2.3", "1.2.3", 1'b1, V_LBAD});
    rows.push_back(row_t'{"3.2.1", "", 1'b1, V_RBAD});
    rows.push_back(row_t'{"10.20.30", "10.20.4", 1'b0, V_NONE});
    rows.push_back(row_t'{"00000.1.65534", "0.1.65535", 1'b0, V_NONE});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < rows.size(); r++)
      send_strings(to_text(rows[r].left_text), to_text(rows[r].right_text), 1'b0,
                   rows[r].typed, rows[r].want);

    // random pairs through all idling phases
    while (items_sent < ITEM_GOAL) send_random_pair();
    in_ch.valid = 1'b0;

    // drain outstanding results, then keep watching for stray ones
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("testbench: %0d character pairs sent, %0d string pairs compared",
             items_sent, verdicts_seen);
    $display("testbench: %0d left newer, %0d left older, %0d with an invalid lane",
             newer_seen, older_seen, invalid_seen);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
